### rtl/mhpq_pkg.sv
// Shared constants, codes and types of the max-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

	// Default sizes of the heap store
	localparam int HEAP_DEPTH_DEF = 1024;
	localparam int KEY_WIDTH_DEF  = 32;

	// Capacity register and reported count
	localparam int CFG_W       = 11;
	localparam int COUNT_OUT_W = 11;
	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(1024);

	// Request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// Non-key part of a result beat
	typedef struct packed {
		status_t                  status;
		logic                     top_valid;
		logic [COUNT_OUT_W-1:0]   element_count;
	} res_meta_t;

endpackage

`default_nettype wire

### rtl/mhpq_if.sv
// Channel interfaces: request, result and capacity write.
`timescale 1ns / 1ps
`default_nettype none

interface mhpq_req_if
	import mhpq_pkg::*;
	#(parameter int KEY_WIDTH = KEY_WIDTH_DEF);
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic [KEY_WIDTH-1:0] key_in;

	modport source (output valid, output req_type, output key_in, input ready);
	modport sink   (input valid, input req_type, input key_in, output ready);
endinterface

interface mhpq_rsp_if
	import mhpq_pkg::*;
	#(parameter int KEY_WIDTH = KEY_WIDTH_DEF);
	logic                   valid;
	logic                   ready;
	logic [1:0]             status;
	logic [KEY_WIDTH-1:0]   removed_key;
	logic [KEY_WIDTH-1:0]   top_key;
	logic                   top_valid;
	logic [COUNT_OUT_W-1:0] element_count;

	modport source (output valid, output status, output removed_key, output top_key,
		output top_valid, output element_count, input ready);
	modport sink   (input valid, input status, input removed_key, input top_key,
		input top_valid, input element_count, output ready);
endinterface

interface mhpq_cfg_if
	import mhpq_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] capacity_limit;

	modport source (output valid, output capacity_limit, input ready);
	modport sink   (input valid, input capacity_limit, output ready);
endinterface

`default_nettype wire

### rtl/mhpq_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr_a,
	input  wire logic [AW-1:0]    rd_addr_b,
	output logic      [WIDTH-1:0] rd_data_a,
	output logic      [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Register both reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

`default_nettype wire

### rtl/mhpq_engine.sv
// Sift engine: count, root copy and the read-modify-write walk of the heap store.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_engine
	import mhpq_pkg::*;
#(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
	parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [CFG_W-1:0]     cap,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 in_type,
	input  wire logic [KEY_WIDTH-1:0] in_key,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output res_meta_t                 res_meta,
	output logic      [KEY_WIDTH-1:0] res_removed,
	output logic      [KEY_WIDTH-1:0] res_top
);

	localparam int ADDR_W = $clog2(HEAP_DEPTH);
	localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
	localparam int IDX_W  = CNT_W + 1;
	localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_UP      = 6'b000010,
		S_DN_LAST = 6'b000100,
		S_DN      = 6'b001000,
		S_FIN     = 6'b010000,
		S_DONE    = 6'b100000
	} state_t;

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [ADDR_W-1:0]     pos_q, pos_d;
	logic [KEY_WIDTH-1:0]  key_q, key_d;
	logic [KEY_WIDTH-1:0]  top_q;
	status_t               status_q, status_d;
	logic [KEY_WIDTH-1:0]  removed_q, removed_d;

	logic                  wr_en, rd_en;
	logic [ADDR_W-1:0]     wr_addr, rd_addr_a, rd_addr_b;
	logic [KEY_WIDTH-1:0]  wr_data, rd_data_a, rd_data_b;

	logic                  in_fire, ins_ok;
	logic [ADDR_W-1:0]     par, cnt_par, pick;
	logic [IDX_W-1:0]      n_ext, l_idx, r_idx, l2_idx, r2_idx;
	logic                  pick_r;
	logic [KEY_WIDTH-1:0]  cval;

	mhpq_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (HEAP_DEPTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	// Room left under both the register limit and the store depth
	assign ins_ok = (CMP_W'(count_q) < CMP_W'(cap)) && (count_q < CNT_W'(HEAP_DEPTH));

	// Index arithmetic for the current position
	assign n_ext   = IDX_W'(count_q);
	assign par     = ADDR_W'((pos_q - 1'b1) >> 1);
	assign cnt_par = ADDR_W'((count_q - 1'b1) >> 1);
	assign l_idx   = (IDX_W'(pos_q) << 1) + IDX_W'(1);
	assign r_idx   = l_idx + IDX_W'(1);
	assign pick_r  = (r_idx < n_ext) && (rd_data_b >= rd_data_a);
	assign cval    = pick_r ? rd_data_b : rd_data_a;
	assign pick    = pick_r ? ADDR_W'(r_idx) : ADDR_W'(l_idx);
	assign l2_idx  = (IDX_W'(pick) << 1) + IDX_W'(1);
	assign r2_idx  = l2_idx + IDX_W'(1);

	// Next state, memory accesses and result fields
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pos_d     = pos_q;
		key_d     = key_q;
		status_d  = status_q;
		removed_d = removed_q;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = key_q;
		rd_en     = 1'b0;
		rd_addr_a = par;
		rd_addr_b = par;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					status_d  = STAT_OK;
					removed_d = '0;
					pos_d     = '0;
					key_d     = in_key;
					state_d   = S_DONE;
					if (in_type == REQ_INSERT) begin
						if (!ins_ok) begin
							status_d = STAT_FULL;
						end else begin
							count_d = count_q + 1'b1;
							pos_d   = ADDR_W'(count_q);
							if (count_q == '0) begin
								wr_en   = 1'b1;
								wr_addr = '0;
								wr_data = in_key;
							end else begin
								rd_en     = 1'b1;
								rd_addr_a = cnt_par;
								rd_addr_b = cnt_par;
								state_d   = S_UP;
							end
						end
					end else begin
						if (count_q == '0) begin
							status_d = STAT_EMPTY;
						end else begin
							removed_d = top_q;
							count_d   = count_q - 1'b1;
							if (count_q != CNT_W'(1)) begin
								rd_en     = 1'b1;
								rd_addr_a = ADDR_W'(count_q - 1'b1);
								rd_addr_b = ADDR_W'(count_q - 1'b1);
								state_d   = S_DN_LAST;
							end
						end
					end
				end
			end
			S_UP: begin
				// Move the parent down into the hole while the key is larger
				wr_en = 1'b1;
				if (key_q > rd_data_a) begin
					wr_data = rd_data_a;
					pos_d   = par;
					if (par == '0) begin
						state_d = S_FIN;
					end else begin
						rd_en     = 1'b1;
						rd_addr_a = ADDR_W'((par - 1'b1) >> 1);
						rd_addr_b = ADDR_W'((par - 1'b1) >> 1);
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_DN_LAST: begin
				// Take the last key as the one to sift from the root
				key_d = rd_data_a;
				if (n_ext > IDX_W'(1)) begin
					rd_en     = 1'b1;
					rd_addr_a = ADDR_W'(1);
					rd_addr_b = (n_ext > IDX_W'(2)) ? ADDR_W'(2) : ADDR_W'(1);
					state_d   = S_DN;
				end else begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = rd_data_a;
					state_d = S_DONE;
				end
			end
			S_DN: begin
				// Pull the larger child up while it beats the key
				wr_en = 1'b1;
				if (cval > key_q) begin
					wr_data = cval;
					pos_d   = pick;
					if (l2_idx < n_ext) begin
						rd_en     = 1'b1;
						rd_addr_a = ADDR_W'(l2_idx);
						rd_addr_b = (r2_idx < n_ext) ? ADDR_W'(r2_idx) : ADDR_W'(l2_idx);
					end else begin
						state_d = S_FIN;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_FIN: begin
				wr_en   = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		key_q     <= key_d;
		status_q  <= status_d;
		removed_q <= removed_d;
		if (wr_en && (wr_addr == '0)) begin
			top_q <= wr_data;
		end
	end

	assign res_valid              = (state_q == S_DONE);
	assign res_meta.status        = status_q;
	assign res_meta.top_valid     = (count_q != '0);
	assign res_meta.element_count = COUNT_OUT_W'(count_q);
	assign res_removed            = removed_q;
	assign res_top                = (count_q != '0) ? top_q : '0;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HEAP_DEPTH))
		else $error("heap count above depth");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr_a && wr_addr != rd_addr_b))
		else $error("read and write of the same entry in one cycle");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !in_fire) |-> !wr_en)
		else $error("store written while idle");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (count_q == $past(count_q) || count_q == CNT_W'($past(count_q) + 1'b1)
			|| count_q == CNT_W'($past(count_q) - 1'b1)))
		else $error("count moved by more than one");

	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_DONE) |=> $stable(count_q))
		else $error("count changed during a sift");
`endif

endmodule

`default_nettype wire

### rtl/mhpq_out_reg.sv
// Result output register between the sift engine and the result channel.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_out_reg
	import mhpq_pkg::*;
#(
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire res_meta_t            in_meta,
	input  wire logic [KEY_WIDTH-1:0] in_removed,
	input  wire logic [KEY_WIDTH-1:0] in_top,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output res_meta_t                 out_meta,
	output logic      [KEY_WIDTH-1:0] out_removed,
	output logic      [KEY_WIDTH-1:0] out_top
);

	logic valid_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	// Hold a beat until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Load payload with each new beat
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_meta    <= in_meta;
			out_removed <= in_removed;
			out_top     <= in_top;
		end
	end

endmodule

`default_nettype wire

### rtl/max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue.
//
//   channel  modport  beat carries
//   cfg      sink     capacity_limit
//   req      sink     req_type, key_in
//   rsp      source   status, removed_key, top_key, top_valid, element_count
//
// An insert sifts up from the new leaf and a remove sifts down from the root:
// one level of the heap per cycle through the registered read of the heap store.
// Full, empty and single-key cases finish without a walk of the heap.
// Reset clears the count and state; the store itself needs no clearing pass.
// A new request is taken while the previous result waits in the output register;
// a stalled result holds the engine once its next result is ready.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue
	import mhpq_pkg::*;
#(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
	parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mhpq_cfg_if.sink   cfg,
	mhpq_req_if.sink   req,
	mhpq_rsp_if.source rsp
);

	logic [CFG_W-1:0]     cap_q;
	logic                 eng_valid, eng_ready;
	res_meta_t            eng_meta, out_meta;
	logic [KEY_WIDTH-1:0] eng_removed, eng_top;

	// Capacity register, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.capacity_limit;
		end
	end

	mhpq_engine #(
		.HEAP_DEPTH (HEAP_DEPTH),
		.KEY_WIDTH  (KEY_WIDTH)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cap         (cap_q),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.in_type     (req.req_type),
		.in_key      (req.key_in),
		.res_valid   (eng_valid),
		.res_ready   (eng_ready),
		.res_meta    (eng_meta),
		.res_removed (eng_removed),
		.res_top     (eng_top)
	);

	mhpq_out_reg #(
		.KEY_WIDTH (KEY_WIDTH)
	) u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (eng_valid),
		.in_ready    (eng_ready),
		.in_meta     (eng_meta),
		.in_removed  (eng_removed),
		.in_top      (eng_top),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_meta    (out_meta),
		.out_removed (rsp.removed_key),
		.out_top     (rsp.top_key)
	);

	// Unpack the result fields
	assign rsp.status        = out_meta.status;
	assign rsp.top_valid     = out_meta.top_valid;
	assign rsp.element_count = out_meta.element_count;

endmodule

`default_nettype wire
